// ----- rtl/stx_crlf_frame_receiver_core_defines.svh -----
// assertion macros shared by the checker of the frame receiver
`ifndef STX_CRLF_FRAME_RECEIVER_CORE_DEFINES_SVH
`define STX_CRLF_FRAME_RECEIVER_CORE_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define SCFR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scfr check failed");

// consequent must hold in the cycle after the antecedent
`define SCFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scfr check failed");

`endif

// ----- rtl/scfr_pkg.sv -----
// types and constants of the stx / cr-lf frame receiver
`default_nettype none

package scfr_pkg;

  // frame buffer size, the frame closes with an overflow one byte short of it
  localparam int unsigned BufferBytes = 128;
  localparam int unsigned FrameLimit  = (BufferBytes - 1 > 127) ? 127 : BufferBytes - 1;

  // configuration register indexes
  localparam logic [1:0] RegStartChar = 2'd0;
  localparam logic [1:0] RegCrChar    = 2'd1;
  localparam logic [1:0] RegLfChar    = 2'd2;

  // reset values of the configuration registers
  localparam logic [7:0] StartCharRst = 8'h02;
  localparam logic [7:0] CrCharRst    = 8'h0D;
  localparam logic [7:0] LfCharRst    = 8'h0A;

  // request kinds
  localparam logic ReqByte    = 1'b0;
  localparam logic ReqService = 1'b1;

  // service status codes
  localparam logic [1:0] StatusNone     = 2'd0;
  localparam logic [1:0] StatusGood     = 2'd1;
  localparam logic [1:0] StatusOverflow = 2'd2;

  // command codes
  localparam logic [2:0] CmdNone    = 3'd0;
  localparam logic [2:0] CmdRead    = 3'd1;
  localparam logic [2:0] CmdWrite   = 3'd2;
  localparam logic [2:0] CmdSet     = 3'd3;
  localparam logic [2:0] CmdUnknown = 3'd4;

  // ascii characters used by the decoder
  localparam logic [7:0] AsciiZero  = 8'h30;
  localparam logic [7:0] CharUpperR = 8'h52;
  localparam logic [7:0] CharLowerR = 8'h72;
  localparam logic [7:0] CharUpperW = 8'h57;
  localparam logic [7:0] CharLowerW = 8'h77;
  localparam logic [7:0] CharUpperS = 8'h53;
  localparam logic [7:0] CharLowerS = 8'h73;

  typedef logic [3:0][7:0] head_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic       receiving;
    logic       frame_over;
    logic [1:0] service_status;
    logic [2:0] command;
    logic [7:0] read_index;
    logic [6:0] frame_length;
  } out_item_t;

endpackage

`default_nettype wire

// ----- rtl/scfr_if.sv -----
// valid / ready channel interfaces of the frame receiver
`default_nettype none

interface scfr_in_if;
  import scfr_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface scfr_out_if;
  import scfr_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

`default_nettype wire

// ----- rtl/scfr_decode.sv -----
// command and read index decode of a completed frame
`default_nettype none

module scfr_decode (
  input  scfr_pkg::head_t    head_i,
  output logic [2:0]         command_o,
  output logic [7:0]         read_index_o
);
  import scfr_pkg::*;

  logic [7:0] hundreds;
  logic [7:0] tens;
  logic [7:0] units;

  // digits weighted 100, 10, 1, all kept mod 256
  assign hundreds = 8'((head_i[1] - AsciiZero) * 8'd100);
  assign tens     = 8'((head_i[2] - AsciiZero) * 8'd10);
  assign units    = head_i[3] - AsciiZero;

  always_comb begin
    read_index_o = 8'd0;
    if (head_i[0] == CharUpperR || head_i[0] == CharLowerR) begin
      command_o    = CmdRead;
      read_index_o = hundreds + tens + units;
    end else if (head_i[0] == CharUpperW || head_i[0] == CharLowerW) begin
      command_o = CmdWrite;
    end else if (head_i[0] == CharUpperS || head_i[0] == CharLowerS) begin
      command_o = CmdSet;
    end else begin
      command_o = CmdUnknown;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/stx_crlf_frame_receiver_core.sv -----
// top level of the stx / cr-lf frame receiver
//
// Collects serial bytes into frames that open with the start character and close
// on a line feed that directly follows a carriage return, or with an overflow
// once the stored count reaches the frame limit; a service transaction on an
// ended frame decodes a good frame's first byte into read / write / set /
// unknown, gives the three-digit read index of a read, and clears the frame.
// Every input transaction yields exactly one result transaction. One
// transaction is taken per clock cycle while the result side does not stall;
// the input register feeds the combinational frame state update, whose
// result is loaded into the result register when the pipe advances.
// Back-pressure on the result side stalls both stages, and the input side
// keeps taking transactions while the result register is free or being drained.
// Configuration is over an apb-style port (start, cr and lf characters at byte
// addresses 0, 4, 8) and is expected only while idle.
`default_nettype none

module stx_crlf_frame_receiver_core (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  scfr_in_if.sink           in_i,
  scfr_out_if.source        out_o,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [3:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import scfr_pkg::*;

  // configuration registers
  logic [7:0] start_char_q;
  logic [7:0] cr_char_q;
  logic [7:0] lf_char_q;
  logic       cfg_write;

  // pipeline registers
  logic      in_valid_q;
  in_item_t  in_q;
  logic      out_valid_q;
  out_item_t out_q;
  out_item_t out_d;
  logic      advance;
  logic      fire;

  // frame state
  logic       in_frame_q, in_frame_d;
  logic       ended_q, ended_d;
  logic       ok_q, ok_d;
  logic [6:0] count_q, count_d;
  head_t      head_q, head_d;
  logic [7:0] last_q, last_d;

  // decoded view of the stored head bytes
  logic [2:0] dec_command;
  logic [7:0] dec_read_index;

  // apb register access, pready always high
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_char_q <= StartCharRst;
      cr_char_q    <= CrCharRst;
      lf_char_q    <= LfCharRst;
    end else if (cfg_write) begin
      case (paddr[3:2])
        RegStartChar: start_char_q <= pwdata[7:0];
        RegCrChar:    cr_char_q    <= pwdata[7:0];
        RegLfChar:    lf_char_q    <= pwdata[7:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegStartChar: prdata = {24'd0, start_char_q};
      RegCrChar:    prdata = {24'd0, cr_char_q};
      RegLfChar:    prdata = {24'd0, lf_char_q};
      default:      prdata = 32'd0;
    endcase
  end

  // handshake: the whole pipe moves when the result register is free or drained
  assign advance     = !out_valid_q || out_o.ready;
  assign fire        = in_valid_q && advance;
  assign in_i.ready  = !in_valid_q || advance;
  assign out_o.valid = out_valid_q;
  assign out_o.item  = out_q;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q <= in_i.item;
    end
  end

  scfr_decode u_decode (
    .head_i       (head_q),
    .command_o    (dec_command),
    .read_index_o (dec_read_index)
  );

  // frame state update for the transaction in the input register
  always_comb begin
    in_frame_d = in_frame_q;
    ended_d    = ended_q;
    ok_d       = ok_q;
    count_d    = count_q;
    head_d     = head_q;
    last_d     = last_q;

    out_d.service_status = StatusNone;
    out_d.command        = CmdNone;
    out_d.read_index     = 8'd0;

    if (in_q.req_type == ReqByte) begin
      // bytes are ignored once a frame has ended
      if (!ended_q) begin
        if (in_frame_q) begin
          if (in_q.rx_byte == lf_char_q && count_q != 7'd0 && last_q == cr_char_q) begin
            // good terminator, the line feed is not stored
            ended_d = 1'b1;
            ok_d    = 1'b1;
          end else begin
            if (count_q < 7'd4) begin
              head_d[count_q[1:0]] = in_q.rx_byte;
            end
            last_d  = in_q.rx_byte;
            count_d = count_q + 7'd1;
            if (count_d >= 7'(FrameLimit)) begin
              ended_d = 1'b1;
              ok_d    = 1'b0;
            end
          end
        end else if (in_q.rx_byte == start_char_q) begin
          // start character opens the frame and is not stored
          in_frame_d = 1'b1;
        end
      end
    end else if (ended_q) begin
      if (ok_q) begin
        out_d.service_status = StatusGood;
        out_d.command        = dec_command;
        out_d.read_index     = dec_read_index;
      end else begin
        out_d.service_status = StatusOverflow;
      end
      // service clears the whole frame
      in_frame_d = 1'b0;
      ended_d    = 1'b0;
      ok_d       = 1'b0;
      count_d    = 7'd0;
      head_d     = '0;
      last_d     = 8'd0;
    end

    out_d.receiving    = in_frame_d && !ended_d;
    out_d.frame_over   = ended_d;
    out_d.frame_length = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      ended_q    <= 1'b0;
      ok_q       <= 1'b0;
      count_q    <= 7'd0;
      head_q     <= '0;
      last_q     <= 8'd0;
    end else if (fire) begin
      in_frame_q <= in_frame_d;
      ended_q    <= ended_d;
      ok_q       <= ok_d;
      count_q    <= count_d;
      head_q     <= head_d;
      last_q     <= last_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= out_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/scfr_checker.sv -----
// port-level checks of the frame receiver and their binding
`default_nettype none
`include "stx_crlf_frame_receiver_core_defines.svh"

module scfr_checker (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire scfr_pkg::out_item_t  out_item
);
  import scfr_pkg::*;

  // a stalled result holds its payload
  `SCFR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni,
                    out_valid && !out_ready,
                    out_valid && $stable(out_item))

  // a serviced frame always leaves the receiver cleared
  `SCFR_ASSERT_SAME(a_service_clears, clk_i, rst_ni,
                    out_valid && out_item.service_status != StatusNone,
                    !out_item.receiving && !out_item.frame_over &&
                    out_item.frame_length == 7'd0)

  // commands come only from good frames
  `SCFR_ASSERT_SAME(a_cmd_good, clk_i, rst_ni,
                    out_valid && out_item.command != CmdNone,
                    out_item.service_status == StatusGood)

  // a read index only accompanies a read command
  `SCFR_ASSERT_SAME(a_index_read, clk_i, rst_ni,
                    out_valid && out_item.read_index != 8'd0,
                    out_item.command == CmdRead)

  // an open frame is never also an ended one
  `SCFR_ASSERT_SAME(a_open_xor_over, clk_i, rst_ni,
                    out_valid && out_item.receiving,
                    !out_item.frame_over)

endmodule

bind stx_crlf_frame_receiver_core scfr_checker u_scfr_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_item  (out_o.item)
);

`default_nettype wire
